// File: rtl/tts_pkg.sv
`default_nettype none

package tts_pkg;

  // Field widths of the configuration port and of the payloads
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned OFFSET_W  = 22;
  localparam int unsigned PAD_W     = 11;

  // Texture geometry
  localparam int unsigned MIN_SIDE  = 64;
  localparam int unsigned MIN_LOG   = 6;
  localparam int unsigned TILE_LOG  = 3;
  localparam int unsigned SIDE_RST  = 64;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RGB_MODE     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] dest_offset;
    logic [CH_W-1:0]     alpha_out;
    logic [CH_W-1:0]     blue_out;
    logic [CH_W-1:0]     green_out;
    logic [CH_W-1:0]     red_out;
    logic [PAD_W-1:0]    padded_width;
    logic [PAD_W-1:0]    padded_height;
    logic                last_pixel;
  } texel_t;

  typedef struct packed {
    logic             rgb_mode;
    logic [PAD_W-1:0] padded_width;
    logic [PAD_W-1:0] padded_height;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/tts_stream_if.sv
`default_nettype none

interface tts_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: rtl/tts_cfg.sv
`default_nettype none

module tts_cfg #(
  parameter int unsigned MAX_SIDE = 1024,
  localparam int unsigned CW = $clog2(MAX_SIDE),
  localparam int unsigned LW = $clog2(CW + 1)
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [tts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [tts_pkg::CFG_W-1:0]       cfg_wdata_i,
  output tts_pkg::cfg_t                   cfg_o,
  output logic [CW-1:0]                   w_last_o,
  output logic [CW-1:0]                   h_last_o,
  output logic [LW-1:0]                   w_log_o,
  output logic                            restart_o
);

  localparam int unsigned LOG_RST =
      ($clog2(tts_pkg::SIDE_RST) > tts_pkg::MIN_LOG) ? $clog2(tts_pkg::SIDE_RST)
                                                     : tts_pkg::MIN_LOG;

  logic [CW-1:0]             side_m1_d;
  logic [LW-1:0]             log_d;
  logic [tts_pkg::PAD_W-1:0] pad_d;

  logic [CW-1:0]             w_last_q;
  logic [CW-1:0]             h_last_q;
  logic [LW-1:0]             w_log_q;
  logic [tts_pkg::PAD_W-1:0] pad_w_q;
  logic [tts_pkg::PAD_W-1:0] pad_h_q;
  logic                      rgb_q;

  // Clamp the written side to 1..MAX_SIDE, keep side-1 and the padded log2
  always_comb begin
    if (cfg_wdata_i == '0) begin
      side_m1_d = '0;
    end else if (32'(cfg_wdata_i) > MAX_SIDE) begin
      side_m1_d = CW'(MAX_SIDE - 1);
    end else begin
      side_m1_d = CW'(cfg_wdata_i - 1'b1);
    end
    log_d = LW'(tts_pkg::MIN_LOG);
    for (int i = 0; i < CW; i++) begin
      if (side_m1_d[i] && (i + 1 > tts_pkg::MIN_LOG)) begin
        log_d = LW'(i + 1);
      end
    end
    pad_d = tts_pkg::PAD_W'(32'd1 << log_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= CW'(tts_pkg::SIDE_RST - 1);
      h_last_q <= CW'(tts_pkg::SIDE_RST - 1);
      w_log_q  <= LW'(LOG_RST);
      pad_w_q  <= tts_pkg::PAD_W'(32'd1 << LOG_RST);
      pad_h_q  <= tts_pkg::PAD_W'(32'd1 << LOG_RST);
      rgb_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tts_pkg::REG_IMAGE_WIDTH: begin
          w_last_q <= side_m1_d;
          w_log_q  <= log_d;
          pad_w_q  <= pad_d;
        end
        tts_pkg::REG_IMAGE_HEIGHT: begin
          h_last_q <= side_m1_d;
          pad_h_q  <= pad_d;
        end
        tts_pkg::REG_RGB_MODE: begin
          rgb_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign restart_o = cfg_we_i && ((cfg_index_i == tts_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index_i == tts_pkg::REG_IMAGE_HEIGHT));

  assign cfg_o.rgb_mode      = rgb_q;
  assign cfg_o.padded_width  = pad_w_q;
  assign cfg_o.padded_height = pad_h_q;
  assign w_last_o            = w_last_q;
  assign h_last_o            = h_last_q;
  assign w_log_o             = w_log_q;

endmodule

`default_nettype wire

// File: rtl/tts_scan.sv
`default_nettype none

module tts_scan #(
  parameter int unsigned CW = 10
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  tts_stream_if.sink            pix_i,
  input  wire  [CW-1:0]         w_last_i,
  input  wire  [CW-1:0]         h_last_i,
  input  wire                   restart_i,
  input  wire                   rgb_mode_i,
  input  wire                   s1_ready_i,
  output logic                  s1_valid_o,
  output tts_pkg::pixel_t       pixel_o,
  output logic [CW-1:0]         col_o,
  output logic [CW-1:0]         row_o,
  output logic                  last_o
);

  logic [CW-1:0]   col_q;
  logic [CW-1:0]   row_q;
  logic            valid_q;
  tts_pkg::pixel_t pixel_d;
  tts_pkg::pixel_t pixel_q;
  logic [CW-1:0]   col_s_q;
  logic [CW-1:0]   row_s_q;
  logic            last_q;

  logic            accept;
  logic            col_end;
  logic            row_end;

  assign pix_i.ready = !valid_q || s1_ready_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign col_end     = col_q >= w_last_i;
  assign row_end     = row_q >= h_last_i;

  // Force alpha opaque for an RGB source
  always_comb begin
    pixel_d = pix_i.data;
    if (rgb_mode_i) begin
      pixel_d.alpha_in = tts_pkg::ALPHA_OPAQUE;
    end
  end

  // Raster position, wraps to the origin after the last pixel or on a size write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (s1_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= pixel_d;
      col_s_q <= col_q;
      row_s_q <= row_q;
      last_q  <= col_end && row_end;
    end
  end

  assign s1_valid_o = valid_q;
  assign pixel_o    = pixel_q;
  assign col_o      = col_s_q;
  assign row_o      = row_s_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// File: rtl/tts_tiler.sv
`default_nettype none

module tts_tiler #(
  parameter int unsigned CW = 10,
  parameter int unsigned LW = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s1_valid_i,
  output logic                  s1_ready_o,
  input  wire  tts_pkg::pixel_t pixel_i,
  input  wire  [CW-1:0]         col_i,
  input  wire  [CW-1:0]         row_i,
  input  wire                   last_i,
  input  wire  [LW-1:0]         w_log_i,
  input  wire  tts_pkg::cfg_t   cfg_i,
  tts_stream_if.source          tex_o
);

  localparam int unsigned TW = 2 * (CW - tts_pkg::TILE_LOG) + 1;
  localparam int unsigned FW = TW + 2 * tts_pkg::TILE_LOG + 2;

  logic [5:0]      morton;
  logic [TW-1:0]   tile;
  logic [FW-1:0]   offset_full;
  logic [LW-1:0]   row_shift;
  tts_pkg::texel_t tex_d;
  tts_pkg::texel_t tex_q;
  logic            valid_q;
  logic            take;

  assign s1_ready_o = !valid_q || tex_o.ready;
  assign take       = s1_valid_i && s1_ready_o;

  // Interleave x0,y0,x1,y1,x2,y2 inside the tile; tiles are row-major
  assign morton    = {row_i[2], col_i[2], row_i[1], col_i[1], row_i[0], col_i[0]};
  assign row_shift = LW'(w_log_i - LW'(tts_pkg::TILE_LOG));
  assign tile      = (TW'(row_i >> tts_pkg::TILE_LOG) << row_shift)
                   + TW'(col_i >> tts_pkg::TILE_LOG);
  assign offset_full = {tile, morton, 2'b00};

  always_comb begin
    tex_d.dest_offset   = tts_pkg::OFFSET_W'(offset_full);
    tex_d.alpha_out     = pixel_i.alpha_in;
    tex_d.blue_out      = pixel_i.blue_in;
    tex_d.green_out     = pixel_i.green_in;
    tex_d.red_out       = pixel_i.red_in;
    tex_d.padded_width  = cfg_i.padded_width;
    tex_d.padded_height = cfg_i.padded_height;
    tex_d.last_pixel    = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (tex_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tex_q <= tex_d;
    end
  end

  assign tex_o.valid = valid_q;
  assign tex_o.data  = tex_q;

endmodule

`default_nettype wire

// File: rtl/tiled_texture_swizzler_top.sv
// A pixel is held in the input register, then in the result register that drives tex_o.
// Throughput: one pixel per cycle while the sink is ready; the two register
//   stages (input register with the raster counters, result register after
//   the tile address) run concurrently; each frees up as soon as its content moves on.
// Reset: raster position at (0,0), both stages empty, image 64x64 RGBA.
`default_nettype none

module tiled_texture_swizzler_top #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [tts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [tts_pkg::CFG_W-1:0]       cfg_wdata_i,
  tts_stream_if.sink                     pix_i,
  tts_stream_if.source                   tex_o
);

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned LW = $clog2(CW + 1);

  // Configuration, kept in derived form: side-1 for the end-of-line and
  // end-of-image compares, log2 of the padded width for the tile row stride.
  tts_pkg::cfg_t   cfg;
  logic [CW-1:0]   w_last;
  logic [CW-1:0]   h_last;
  logic [LW-1:0]   w_log;
  logic            restart;

  // Input register stage to address stage
  logic            s1_valid;
  logic            s1_ready;
  tts_pkg::pixel_t s1_pixel;
  logic [CW-1:0]   s1_col;
  logic [CW-1:0]   s1_row;
  logic            s1_last;

  tts_cfg #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .w_last_o    (w_last),
    .h_last_o    (h_last),
    .w_log_o     (w_log),
    .restart_o   (restart)
  );

  // Capture the pixel with its raster position and advance the counters;
  // a size write restarts the image at the origin.
  tts_scan #(
    .CW (CW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_i),
    .w_last_i   (w_last),
    .h_last_i   (h_last),
    .restart_i  (restart),
    .rgb_mode_i (cfg.rgb_mode),
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .pixel_o    (s1_pixel),
    .col_o      (s1_col),
    .row_o      (s1_row),
    .last_o     (s1_last)
  );

  // Form the tiled byte offset and hold the texel until the sink takes it
  tts_tiler #(
    .CW (CW),
    .LW (LW)
  ) u_tiler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .pixel_i    (s1_pixel),
    .col_i      (s1_col),
    .row_i      (s1_row),
    .last_i     (s1_last),
    .w_log_i    (w_log),
    .cfg_i      (cfg),
    .tex_o      (tex_o)
  );

`ifndef SYNTHESIS
  // Both stages full and the output stalled: no new pixel may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && tex_o.valid && !tex_o.ready) |-> !pix_i.ready)
    else $error("pixel taken while both stages are full and stalled");

  // A texel offset is always word aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tex_o.valid |-> (tex_o.data.dest_offset[1:0] == 2'b00))
    else $error("texel offset not word aligned");

  // Padded sides are powers of two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tex_o.valid |-> ($onehot0(tex_o.data.padded_width) &&
                     $onehot0(tex_o.data.padded_height)))
    else $error("padded side not a power of two");

  // A stalled first stage still holds its pixel in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |=> s1_valid)
    else $error("first stage dropped a pixel under stall");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tts_pkg::*;

  localparam int unsigned MAX_SIDE    = 1024;
  localparam int unsigned PIXEL_GOAL  = 540;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Tracks the raster position and register copies, and keeps the texels that
  // are still owed by the block, oldest first.
  class texel_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             rgb_reg;
    int unsigned      col;
    int unsigned      row;
    texel_t           owed_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      images;

    function new();
      width_reg  = CFG_W'(SIDE_RST);
      height_reg = CFG_W'(SIDE_RST);
      rgb_reg    = 1'b0;
      col        = 0;
      row        = 0;
      errors     = 0;
      checked    = 0;
      images     = 0;
    endfunction

    static function int unsigned side_used(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
    endfunction

    static function int unsigned padded(int unsigned v);
      int unsigned p;
      p = MIN_SIDE;
      while (p < v) p = p << 1;
      return p;
    endfunction

    function int unsigned image_area();
      return side_used(width_reg) * side_used(height_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = v;
          col = 0;
          row = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = v;
          col = 0;
          row = 0;
        end
        REG_RGB_MODE: rgb_reg = v[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned w, h, wp, hp, tile, morton;
      logic [9:0]  xb, yb;
      texel_t      t;
      w  = side_used(width_reg);
      h  = side_used(height_reg);
      wp = padded(w);
      hp = padded(h);
      xb = 10'(col);
      yb = 10'(row);
      // interleave x and y inside the 8x8 tile, x in the low bit
      morton = 32'({yb[2], xb[2], yb[1], xb[1], yb[0], xb[0]});
      tile   = (row >> TILE_LOG) * (wp >> TILE_LOG) + (col >> TILE_LOG);
      t.dest_offset   = OFFSET_W'(((tile << (2 * TILE_LOG)) + morton) << 2);
      t.alpha_out     = rgb_reg ? ALPHA_OPAQUE : px.alpha_in;
      t.blue_out      = px.blue_in;
      t.green_out     = px.green_in;
      t.red_out       = px.red_in;
      t.padded_width  = PAD_W'(wp);
      t.padded_height = PAD_W'(hp);
      t.last_pixel    = (col + 1 >= w) && (row + 1 >= h);
      owed_q.push_back(t);
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (owed_q.size() == 0) begin
        $error("texel transfer with no pixel outstanding: offset %0d", got.dest_offset);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp("dest_offset", want.dest_offset, got.dest_offset);
      cmp("alpha_out", want.alpha_out, got.alpha_out);
      cmp("blue_out", want.blue_out, got.blue_out);
      cmp("green_out", want.green_out, got.green_out);
      cmp("red_out", want.red_out, got.red_out);
      cmp("padded_width", want.padded_width, got.padded_width);
      cmp("padded_height", want.padded_height, got.padded_height);
      cmp("last_pixel", want.last_pixel, got.last_pixel);
      checked++;
      if (want.last_pixel) images++;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  tts_stream_if #(.payload_t(pixel_t)) pix_if ();
  tts_stream_if #(.payload_t(texel_t)) tex_if ();

  texel_scoreboard sb = new();

  bit          calm;        // phase without idling on either side
  int unsigned cycles;
  int unsigned sent;
  int unsigned cfg_writes;
  int unsigned corner_idx;

  // Byte patterns that put every channel at its extremes and toggle each bit.
  pixel_t corner_pix [6] = '{32'h00000000, 32'hFFFFFFFF, 32'hAA55AA55,
                             32'h55AA55AA, 32'h01020480, 32'h80402001};

  tiled_texture_swizzler_top #(
    .MAX_SIDE(MAX_SIDE)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_if.sink),
    .tex_o      (tex_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run; the budget covers worst-case gaps and stalls many times over.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Check every texel transfer against the oldest owed texel.
  always @(posedge clk_i) begin
    if (rst_ni && tex_if.valid && tex_if.ready) sb.check_texel(tex_if.data);
  end

  // Mostly short gaps, now and then a long one; none in calm phases.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Side length for a random phase: mostly small so whole images finish,
  // sometimes zero, large or past the cap.
  function automatic logic [CFG_W-1:0] pick_side(bit is_width);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(MAX_SIDE + 1, 2047));
    if (r == 2) return CFG_W'($urandom_range(513, MAX_SIDE));
    if (r <= 5) return CFG_W'(is_width ? $urandom_range(9, 130) : $urandom_range(9, 40));
    return CFG_W'(is_width ? $urandom_range(1, 12) : $urandom_range(1, 9));
  endfunction

  // Receiver: hold ready high for a while, then drop it for a random stall.
  initial begin
    int unsigned stall;
    forever begin
      tex_if.ready <= 1'b1;
      repeat (1 + (calm ? 0 : $urandom_range(0, 6))) @(posedge clk_i);
      stall = idle_len();
      if (stall != 0) begin
        tex_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Offer one pixel, after an optional gap, and hold it until the transfer.
  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(px);
    sent++;
  endtask

  task automatic send_corners(int unsigned n);
    repeat (n) begin
      send_pixel(corner_pix[corner_idx % 6]);
      corner_idx++;
    end
  endtask

  // Register write takes effect at the edge where the enable is seen high.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_writes++;
  endtask

  // Stop offering pixels and wait until every owed texel has come out,
  // then idle past the two-stage pipeline before going on.
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned      pick, count;
    logic [CFG_W-1:0] w, h;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_IMAGE_WIDTH;
    cfg_wdata_i  <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    calm         = 1'b0;
    cycles       = 0;
    sent         = 0;
    cfg_writes   = 0;
    corner_idx   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: 64x64 RGBA, first few pixels of the top row.
    send_corners(4);

    // Zero sides count as one: every pixel closes a 1x1 image.
    drain();
    cfg_write(REG_IMAGE_WIDTH, '0);
    cfg_write(REG_IMAGE_HEIGHT, '0);
    cfg_we_i <= 1'b0;
    send_corners(3);

    // RGB mode forces alpha; run a 3x2 image through the wrap and one more.
    drain();
    cfg_write(REG_RGB_MODE, 11'h7FF);
    cfg_write(REG_IMAGE_WIDTH, 11'd3);
    cfg_write(REG_IMAGE_HEIGHT, 11'd2);
    cfg_we_i <= 1'b0;
    send_corners(7);

    // Oversize sides clamp to the cap; the spare index must change nothing.
    drain();
    cfg_write(REG_SPARE, 11'h7FF);
    cfg_write(REG_IMAGE_WIDTH, 11'h7FF);
    cfg_write(REG_IMAGE_HEIGHT, 11'd1025);
    cfg_write(REG_RGB_MODE, 11'h7FE);
    cfg_we_i <= 1'b0;
    send_corners(4);

    // Random phases: mostly whole small images, some partial large ones.
    while (sent < PIXEL_GOAL) begin
      drain();
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        w = pick_side(1'b1);
        h = pick_side(1'b0);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        if ($urandom_range(0, 1)) cfg_write(REG_RGB_MODE, CFG_W'($urandom));
      end else if (pick <= 7) begin
        // mode flip mid-image; the raster position carries on
        cfg_write(REG_RGB_MODE, CFG_W'($urandom));
      end else if (pick == 8) begin
        cfg_write(REG_SPARE, CFG_W'($urandom));
      end
      cfg_we_i <= 1'b0;
      if (sb.image_area() <= 120)
        count = sb.image_area() * $urandom_range(1, 2) + $urandom_range(0, 3);
      else
        count = $urandom_range(8, 40);
      repeat (count) send_pixel(pixel_t'($urandom));
    end

    calm = 1'b0;
    drain();

    $display("summary: %0d pixels sent, %0d texels checked, %0d images completed",
             sent, sb.checked, sb.images);
    $display("summary: %0d register writes, mismatches %0d", cfg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
